/* rtl/core/rlm_pkg.sv */
package rlm_pkg;

	// Line buffer depth and derived widths
	localparam int MAX_WIDTH = 2048;
	localparam int AW        = $clog2(MAX_WIDTH);   // column index
	localparam int CW        = AW + 1;              // column count, may hold MAX_WIDTH

	// Configuration registers
	localparam int CFG_WIDTH_W  = 12;
	localparam int CFG_HEIGHT_W = 16;
	localparam int CFG_DATA_W   = 16;
	localparam int ROW_W        = CFG_HEIGHT_W + 1; // row runs up to height + 1 while draining

	localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 12'd640;
	localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 16'd480;

	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	// Pixel and luminance
	localparam int PIX_W  = 24;     // {red, green, blue}, red in the top byte
	localparam int LUMA_W = 22;
	localparam logic [LUMA_W-1:0] LUMA_KR = 22'd2126;
	localparam logic [LUMA_W-1:0] LUMA_KG = 22'd7152;
	localparam logic [LUMA_W-1:0] LUMA_KB = 22'd722;

	// 3x3 window, column-major: index 3*col + row
	localparam int WIN_N       = 9;
	localparam int MEDIAN_RANK = 4;

	// Output queue
	localparam int FIFO_DEPTH = 8;
	localparam int FP_W       = $clog2(FIFO_DEPTH);
	localparam int FC_W       = $clog2(FIFO_DEPTH + 1);

	typedef logic [PIX_W-1:0]  pix_t;
	typedef logic [LUMA_W-1:0] luma_t;

	typedef struct packed {
		logic res;      // item produces a result
		logic filt;     // result is the window median
		logic last;     // last result of the frame
	} meta_t;

	typedef struct packed {
		logic          en;
		logic [AW-1:0] addr;
	} rd_t;

	typedef struct packed {
		logic          act;     // item updates line stores and window
		logic [AW-1:0] col;
		pix_t          pix;
		meta_t         meta;
	} s1_t;

	typedef struct packed {
		pix_t pix;
		logic filt;
		logic last;
	} out_t;

	function automatic luma_t luma(input pix_t p);
		luma_t r, g, b;
		r = LUMA_W'(p[23:16]);
		g = LUMA_W'(p[15:8]);
		b = LUMA_W'(p[7:0]);
		return r * LUMA_KR + g * LUMA_KG + b * LUMA_KB;
	endfunction

endpackage

/* rtl/core/rlm_ram.sv */
module rlm_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read-first: same-cycle write is not visible
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/core/rlm_ctrl.sv */
module rlm_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic                            cfg_index,
	input  logic [rlm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                            in_fire,
	input  logic                            in_func,
	input  rlm_pkg::pix_t                   in_pix,
	output rlm_pkg::rd_t                    rd,
	output rlm_pkg::s1_t                    s1
);
	import rlm_pkg::*;

	logic [CFG_WIDTH_W-1:0]  width_q;
	logic [CFG_HEIGHT_W-1:0] height_q;
	logic [AW-1:0]           col_q;
	logic [ROW_W-1:0]        row_q;

	logic [CW-1:0]           w_eff;
	logic [CFG_HEIGHT_W-1:0] h_eff;
	logic                    wrap;
	logic [AW-1:0]           c;
	logic [ROW_W-1:0]        r;
	logic [ROW_W-1:0]        r_nx;
	logic [CW-1:0]           c_inc;
	logic                    in_frame;
	logic                    ignore;
	logic                    act;
	logic                    valid;
	logic                    last;
	logic                    interior;

	logic                    act_s1;
	meta_t                   meta_s1;
	logic [AW-1:0]           col_s1;
	pix_t                    pix_s1;

	always_comb begin
		priority if (width_q == '0) begin
			w_eff = CW'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			w_eff = CW'(MAX_WIDTH);
		end else begin
			w_eff = CW'(width_q);
		end
		h_eff = (height_q == '0) ? CFG_HEIGHT_W'(1) : height_q;

		// column left over from a narrower row starts the next row
		wrap = CW'(col_q) >= w_eff;
		c    = wrap ? '0 : col_q;
		r    = wrap ? ROW_W'(row_q + ROW_W'(1)) : row_q;

		in_frame = r < ROW_W'(h_eff);
		ignore   = in_frame && in_func;
		act      = in_fire && !ignore;

		valid    = ((c != '0) && (r != '0)) || ((c == '0) && (r >= ROW_W'(2)));
		last     = (c == '0) && (r > ROW_W'(h_eff));
		interior = (c >= AW'(2)) && (r >= ROW_W'(2)) && in_frame;

		c_inc = CW'(c) + CW'(1);
		r_nx  = r + ROW_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			col_q    <= '0;
			row_q    <= '0;
			act_s1   <= 1'b0;
			meta_s1  <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_IMAGE_WIDTH:  width_q  <= cfg_wdata[CFG_WIDTH_W-1:0];
					REG_IMAGE_HEIGHT: height_q <= cfg_wdata[CFG_HEIGHT_W-1:0];
				endcase
			end
			if (in_fire) begin
				priority if (ignore) begin
					col_q <= c;
					row_q <= r;
				end else if (last) begin
					col_q <= '0;
					row_q <= '0;
				end else if (c_inc >= w_eff) begin
					col_q <= '0;
					row_q <= r_nx;
				end else begin
					col_q <= c_inc[AW-1:0];
					row_q <= r;
				end
			end
			act_s1       <= act;
			meta_s1.res  <= act && valid;
			meta_s1.filt <= act && valid && interior;
			meta_s1.last <= act && last;
		end
	end

	always_ff @(posedge clk) begin
		col_s1 <= c;
		pix_s1 <= in_frame ? in_pix : '0;
	end

	assign rd.en   = act;
	assign rd.addr = c;

	assign s1.act  = act_s1;
	assign s1.col  = col_s1;
	assign s1.pix  = pix_s1;
	assign s1.meta = meta_s1;

endmodule

/* rtl/core/rlm_window.sv */
module rlm_window (
	input  logic           clk,
	input  logic           arst_n,
	input  rlm_pkg::rd_t   rd,
	input  rlm_pkg::s1_t   s1,
	output rlm_pkg::pix_t  win  [rlm_pkg::WIN_N],
	output rlm_pkg::luma_t lum  [rlm_pkg::WIN_N],
	output rlm_pkg::meta_t meta_s2
);
	import rlm_pkg::*;

	logic [CW-1:0] hw_q;        // entries below this were written since reset
	logic          hit_s1;
	logic          fwd_s1;
	pix_t          fwd_top_s1;
	pix_t          fwd_mid_s1;
	pix_t          rd_top;
	pix_t          rd_mid;
	pix_t          top;
	pix_t          mid;
	pix_t          win_q [WIN_N];
	luma_t         lum_q [WIN_N];

	rlm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
		.clk   (clk),
		.we    (s1.act),
		.waddr (s1.col),
		.wdata (mid),
		.re    (rd.en),
		.raddr (rd.addr),
		.rdata (rd_top)
	);

	rlm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
		.clk   (clk),
		.we    (s1.act),
		.waddr (s1.col),
		.wdata (s1.pix),
		.re    (rd.en),
		.raddr (rd.addr),
		.rdata (rd_mid)
	);

	// bypass the write of the item one ahead; never-written entries read as zero
	always_comb begin
		top = fwd_s1 ? fwd_top_s1 : (hit_s1 ? rd_top : '0);
		mid = fwd_s1 ? fwd_mid_s1 : (hit_s1 ? rd_mid : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_q    <= '0;
			hit_s1  <= 1'b0;
			fwd_s1  <= 1'b0;
			meta_s2 <= '0;
			for (int i = 0; i < WIN_N; i++) begin
				win_q[i] <= '0;
				lum_q[i] <= '0;
			end
		end else begin
			meta_s2 <= s1.meta;
			if (rd.en) begin
				hit_s1 <= CW'(rd.addr) < hw_q;
				fwd_s1 <= s1.act && (s1.col == rd.addr);
			end
			if (s1.act) begin
				if (CW'(s1.col) == hw_q) begin
					hw_q <= hw_q + CW'(1);
				end
				for (int i = 0; i < WIN_N - 3; i++) begin
					win_q[i] <= win_q[i+3];
					lum_q[i] <= lum_q[i+3];
				end
				win_q[WIN_N-3] <= top;
				win_q[WIN_N-2] <= mid;
				win_q[WIN_N-1] <= s1.pix;
				lum_q[WIN_N-3] <= luma(top);
				lum_q[WIN_N-2] <= luma(mid);
				lum_q[WIN_N-1] <= luma(s1.pix);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			fwd_top_s1 <= mid;
			fwd_mid_s1 <= s1.pix;
		end
	end

	assign win = win_q;
	assign lum = lum_q;

endmodule

/* rtl/core/rlm_rank.sv */
module rlm_rank (
	input  logic           clk,
	input  logic           arst_n,
	input  rlm_pkg::pix_t  win [rlm_pkg::WIN_N],
	input  rlm_pkg::luma_t lum [rlm_pkg::WIN_N],
	input  rlm_pkg::meta_t meta_s2,
	output logic           push,
	output rlm_pkg::out_t  push_data,
	output rlm_pkg::meta_t meta_s3
);
	import rlm_pkg::*;

	logic [WIN_N-1:0] beats    [WIN_N];    // beats[i][j]: window entry j ranks below i
	logic [WIN_N-1:0] beats_s3 [WIN_N];
	pix_t             pix_s3   [WIN_N];
	logic [WIN_N-1:0] sel;
	pix_t             med;

	always_comb begin
		for (int i = 0; i < WIN_N; i++) begin
			for (int j = 0; j < WIN_N; j++) begin
				beats[i][j] = (lum[j] < lum[i]) || ((lum[j] == lum[i]) && (j < i));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s3 <= '0;
		end else begin
			meta_s3 <= meta_s2;
		end
	end

	always_ff @(posedge clk) begin
		beats_s3 <= beats;
		pix_s3   <= win;
	end

	// ties are broken by position, so exactly one entry has the median rank
	always_comb begin
		med = '0;
		for (int i = 0; i < WIN_N; i++) begin
			sel[i] = $countones(beats_s3[i]) == MEDIAN_RANK;
			med    = med | (pix_s3[i] & {PIX_W{sel[i]}});
		end
	end

	assign push           = meta_s3.res;
	assign push_data.pix  = meta_s3.filt ? med : pix_s3[WIN_N/2];
	assign push_data.filt = meta_s3.filt;
	assign push_data.last = meta_s3.last;

endmodule

/* rtl/core/rlm_ofifo.sv */
module rlm_ofifo (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  rlm_pkg::out_t              push_data,
	output logic [rlm_pkg::FC_W-1:0]   cnt,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [rlm_pkg::PIX_W-1:0]  m_axis_tdata,
	output logic                       m_axis_tuser,
	output logic                       m_axis_tlast
);
	import rlm_pkg::*;

	out_t            mem_q [FIFO_DEPTH];
	logic [FP_W-1:0] wr_q;
	logic [FP_W-1:0] rd_q;
	logic [FC_W-1:0] cnt_q;
	logic            pop;
	out_t            head;

	assign pop  = (cnt_q != '0) && m_axis_tready;
	assign head = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + FP_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + FP_W'(1);
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + FC_W'(1);
				2'b01:   cnt_q <= cnt_q - FC_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	assign cnt           = cnt_q;
	assign m_axis_tvalid = cnt_q != '0;
	assign m_axis_tdata  = {head.pix[7:0], head.pix[15:8], head.pix[23:16]};
	assign m_axis_tuser  = head.filt;
	assign m_axis_tlast  = head.last;

endmodule

/* rtl/core/rgb_luma_median_3x3.sv */
// Result order: a pixel's result leaves image_width + 1 transactions after it enters, then
//   passes the pipeline registers (line-store read, window, rank compare) and the queue.
// Throughput: one transaction per clock, sustained; the line stores take one read and
//   one write per cycle, and input ready is held off only when the 8-entry output queue
//   plus the results in flight fill it.
// Reset (arst_n, async, active low): counters, window and queue clear, width 640, height 480.
module rgb_luma_median_3x3 (
	input  logic                            clk,
	input  logic                            arst_n,

	// configuration: index 0 = image_width (12 bit), 1 = image_height (16 bit)
	input  logic                            cfg_we,
	input  logic                            cfg_index,
	input  logic [rlm_pkg::CFG_DATA_W-1:0]  cfg_wdata,

	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [rlm_pkg::PIX_W-1:0]       s_axis_tdata,   // red_in, green_in, blue_in
	input  logic                            s_axis_tuser,   // func

	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [rlm_pkg::PIX_W-1:0]       m_axis_tdata,   // red_out, green_out, blue_out
	output logic                            m_axis_tuser,   // was_filtered
	output logic                            m_axis_tlast    // frame_end
);
	import rlm_pkg::*;

	logic            in_fire;
	pix_t            in_pix;
	rd_t             rd;
	s1_t             s1;
	pix_t            win [WIN_N];
	luma_t           lum [WIN_N];
	meta_t           meta_s2;
	meta_t           meta_s3;
	logic            push;
	out_t            push_data;
	logic [FC_W-1:0] cnt;
	logic [FC_W:0]   pend;

	assign in_fire = s_axis_tvalid && s_axis_tready;
	// internal pixel keeps red in the top byte
	assign in_pix  = {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};

	// Credit: every result still in the pipe already owns a queue slot, so the pipe never
	// stalls and the input side never waits on m_axis_tready in the same cycle.
	assign pend = (FC_W+1)'(cnt) + (FC_W+1)'(s1.meta.res) + (FC_W+1)'(meta_s2.res)
		+ (FC_W+1)'(meta_s3.res);
	assign s_axis_tready = pend < (FC_W+1)'(FIFO_DEPTH);

	// Stage 0: position counters, flush handling, line-store read issue
	rlm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_fire   (in_fire),
		.in_func   (s_axis_tuser),
		.in_pix    (in_pix),
		.rd        (rd),
		.s1        (s1)
	);

	// Stage 1: line stores rotate, 3x3 window shifts in the new column with its luma
	rlm_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd      (rd),
		.s1      (s1),
		.win     (win),
		.lum     (lum),
		.meta_s2 (meta_s2)
	);

	// Stages 2-3: pairwise luma compare, rank-4 select, border bypass
	rlm_rank u_rank (
		.clk       (clk),
		.arst_n    (arst_n),
		.win       (win),
		.lum       (lum),
		.meta_s2   (meta_s2),
		.push      (push),
		.push_data (push_data),
		.meta_s3   (meta_s3)
	);

	// Output queue decouples the result side
	rlm_ofifo u_ofifo (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.push_data     (push_data),
		.cnt           (cnt),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// credit scheme must keep the queue from overflowing
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && (cnt == FC_W'(FIFO_DEPTH))))
		else $error("result pushed into full output queue");

	// frame end always carries a result
	a_last_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		meta_s3.last |-> meta_s3.res)
		else $error("frame end marked on an item without result");

	// last pixel of a frame sits on the right border, never filtered
	a_last_is_border: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |-> !m_axis_tuser)
		else $error("frame end pixel flagged as filtered");

	// a transaction accepted now occupies at most the credit left
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (pend <= (FC_W+1)'(FIFO_DEPTH)))
		else $error("pipeline holds more results than queue slots");

endmodule

/* dv/tb_rgb_luma_median_3x3.sv */
`timescale 1ns / 100ps

module tb_rgb_luma_median_3x3;
	import rlm_pkg::*;

	// Clock, reset and run limits
	localparam int CLK_HIGH      = 5;
	localparam int CLK_LOW       = 5;
	localparam int RESET_CYCLES  = 7;
	localparam int CYCLE_LIMIT   = 40000;
	localparam int SETTLE_CYCLES = 16;       // pipeline is four deep; ignored flushes need time too
	localparam int IDLE_PCT      = 19;       // percent of cycles each side sits out
	localparam int HOLD_CYCLES   = 300;      // long receiver hold-off, fills the output queue
	localparam int RANDOM_PIXELS = 150;
	localparam int PRESS_W       = 32;       // geometry of the back-pressure frame
	localparam int PRESS_H       = 3;

	// Input tuser codes
	localparam logic FUNC_PIXEL = 1'b0;
	localparam logic FUNC_FLUSH = 1'b1;

	// Pixel styles for random frames
	localparam int STYLE_NOISE   = 0;
	localparam int STYLE_PALETTE = 1;    // few colors, many equal-luma ties
	localparam int STYLE_GRAY    = 2;

	// Two pairs of distinct colors with equal luminance: (r+17, g-10, b+49) keeps the sum
	localparam pix_t TIE_A = 24'h104010;
	localparam pix_t TIE_B = 24'h213641;
	localparam pix_t TIE_C = 24'h809020;
	localparam pix_t TIE_D = 24'h918651;

	typedef struct packed {
		logic       func;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} px_item_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       filt;
		logic       last;
	} px_result_t;

	// DUT ports; every input is known from time zero
	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   cfg_we        = 1'b0;
	logic                   cfg_index     = REG_IMAGE_WIDTH;
	logic [CFG_DATA_W-1:0]  cfg_wdata     = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [PIX_W-1:0]       s_axis_tdata  = '0;     // red_in, green_in, blue_in
	logic                   s_axis_tuser  = 1'b0;   // func
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [PIX_W-1:0]       m_axis_tdata;           // red_out, green_out, blue_out
	logic                   m_axis_tuser;           // was_filtered
	logic                   m_axis_tlast;           // frame_end

	rgb_luma_median_3x3 DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#CLK_HIGH clk = 1'b1;
		#CLK_LOW  clk = 1'b0;
	end

	// Stimulus and scoreboard storage
	px_item_t   pending_items[$];
	px_result_t expected_pixels[$];

	// Filter state as the block should hold it
	logic [CFG_WIDTH_W-1:0]  width_reg  = WIDTH_RESET;
	logic [CFG_HEIGHT_W-1:0] height_reg = HEIGHT_RESET;
	pix_t        upper_row  [MAX_WIDTH];
	pix_t        middle_row [MAX_WIDTH];
	pix_t        window     [WIN_N];      // column-major, index 3*col + row
	int unsigned col_ct = 0;
	int unsigned row_ct = 0;

	// Bookkeeping
	int unsigned cycle_ct        = 0;
	int unsigned in_taken        = 0;
	int unsigned results_checked = 0;
	int unsigned filtered_seen   = 0;
	int unsigned frames_closed   = 0;
	int unsigned pixels_sent     = 0;
	int unsigned flushes_sent    = 0;
	int unsigned flushes_ignored = 0;
	int unsigned mismatch_ct     = 0;
	bit          in_handshake    = 1'b0;   // set at posedge, read by the driver at negedge

	// Receiver pressure: the stimulus arms a long hold and a gapless window by item count
	int unsigned hold_at    = 32'hFFFF_FFFF;
	int unsigned hold_left  = 0;
	bit          hold_done  = 1'b0;
	int unsigned gap_from   = 32'hFFFF_FFFF;
	int unsigned gap_to     = 0;

	task automatic log_mismatch(input string msg);
		mismatch_ct++;
		$display("%0t: result %0d: %s", $time, results_checked, msg);
	endtask

	function automatic int unsigned luminance(input pix_t p);
		int unsigned r, g, b;
		r = p[23:16];
		g = p[15:8];
		b = p[7:0];
		return 2126 * r + 7152 * g + 722 * b;
	endfunction

	// Rank 4 of 9 by luminance; equal luminance goes to the lower window index
	function automatic pix_t median_of_window();
		int unsigned l[WIN_N];
		int          rank;
		for (int i = 0; i < WIN_N; i++)
			l[i] = luminance(window[i]);
		for (int i = 0; i < WIN_N; i++) begin
			rank = 0;
			for (int j = 0; j < WIN_N; j++)
				if (l[j] < l[i] || (l[j] == l[i] && j < i))
					rank++;
			if (rank == MEDIAN_RANK)
				return window[i];
		end
		return window[4];
	endfunction

	function automatic int unsigned eff_width();
		if (width_reg == 0)
			return 1;
		if (width_reg > MAX_WIDTH)
			return MAX_WIDTH;
		return width_reg;
	endfunction

	function automatic int unsigned eff_height();
		return (height_reg == 0) ? 1 : height_reg;
	endfunction

	// One accepted transaction through the filter; queues the pixel it releases, if any
	task automatic advance_filter(input px_item_t it);
		int unsigned w, h, c, r, ox, oy;
		pix_t        pix, top, mid, res;
		logic        releases, at_end, interior;
		px_result_t  e;
		w = eff_width();
		h = eff_height();
		// a width lowered mid-frame can leave the column past the row end
		if (col_ct >= w) begin
			col_ct = 0;
			row_ct++;
		end
		c = col_ct;
		r = row_ct;
		if (r < h && it.func == FUNC_FLUSH) begin
			flushes_ignored++;
			return;
		end
		// while draining, pixels behave as flushes and feed zeros
		pix = (r < h) ? {it.red, it.green, it.blue} : '0;
		if (c >= MAX_WIDTH)
			c = 0;
		top = upper_row[c];
		mid = middle_row[c];
		upper_row[c]  = mid;
		middle_row[c] = pix;
		for (int i = 0; i < 6; i++)
			window[i] = window[i + 3];
		window[6] = top;
		window[7] = mid;
		window[8] = pix;

		releases = (c >= 1 && r >= 1) || (c == 0 && r >= 2);
		at_end   = (c == 0 && r >= h + 1);
		if (c + 1 >= w) begin
			col_ct = 0;
			row_ct = r + 1;
		end else begin
			col_ct = c + 1;
		end
		if (at_end) begin
			col_ct = 0;
			row_ct = 0;
			frames_closed++;
		end
		if (!releases)
			return;

		// position of the pixel now leaving: one row and one pixel back
		if (c >= 1) begin
			ox = c - 1;
			oy = r - 1;
		end else begin
			ox = w - 1;
			oy = r - 2;
		end
		interior = w >= 3 && h >= 3 && ox >= 1 && ox <= w - 2 && oy >= 1 && oy <= h - 2;
		res      = interior ? median_of_window() : window[4];
		e.red    = res[23:16];
		e.green  = res[15:8];
		e.blue   = res[7:0];
		e.filt   = interior;
		e.last   = at_end;
		expected_pixels.push_back(e);
	endtask

	task automatic check_result();
		px_result_t want;
		if (expected_pixels.size() == 0) begin
			log_mismatch($sformatf("unexpected transaction data %06h", m_axis_tdata));
			return;
		end
		want = expected_pixels.pop_front();
		if (m_axis_tdata[7:0] !== want.red)
			log_mismatch($sformatf("red %02h, expected %02h", m_axis_tdata[7:0], want.red));
		if (m_axis_tdata[15:8] !== want.green)
			log_mismatch($sformatf("green %02h, expected %02h", m_axis_tdata[15:8], want.green));
		if (m_axis_tdata[23:16] !== want.blue)
			log_mismatch($sformatf("blue %02h, expected %02h", m_axis_tdata[23:16], want.blue));
		if (m_axis_tuser !== want.filt)
			log_mismatch($sformatf("was_filtered %b, expected %b", m_axis_tuser, want.filt));
		if (m_axis_tlast !== want.last)
			log_mismatch($sformatf("frame_end %b, expected %b", m_axis_tlast, want.last));
		if (want.filt)
			filtered_seen++;
		results_checked++;
	endtask

	// Sampling side: config writes, input transactions and output checks, all at posedge
	always @(posedge clk) begin
		px_item_t seen;
		cycle_ct++;
		if (cycle_ct > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still expected",
				cycle_ct, expected_pixels.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			in_handshake = arst_n && s_axis_tvalid && s_axis_tready;
			if (arst_n && cfg_we) begin
				if (cfg_index == REG_IMAGE_WIDTH)
					width_reg = cfg_wdata[CFG_WIDTH_W-1:0];
				else
					height_reg = cfg_wdata[CFG_HEIGHT_W-1:0];
			end
			if (in_handshake) begin
				seen.func  = s_axis_tuser;
				seen.red   = s_axis_tdata[7:0];
				seen.green = s_axis_tdata[15:8];
				seen.blue  = s_axis_tdata[23:16];
				advance_filter(seen);
				in_taken++;
			end
			if (arst_n && m_axis_tvalid && m_axis_tready)
				check_result();
		end
	end

	// Driver: next transaction goes out at negedge once the current one is taken
	always @(negedge clk) begin
		px_item_t head;
		bit       gapless;
		gapless = in_taken >= gap_from && in_taken < gap_to;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || in_handshake) begin
			if (pending_items.size() != 0 && (gapless || $urandom_range(99) >= IDLE_PCT)) begin
				head = pending_items.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= {head.blue, head.green, head.red};
				s_axis_tuser  <= head.func;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, one long hold-off, no stalls in the gapless window
	always @(negedge clk) begin
		bit gapless;
		gapless = in_taken >= gap_from && in_taken < gap_to;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (!hold_done && in_taken >= hold_at) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= gapless || $urandom_range(99) >= IDLE_PCT;
		end
	end

	task automatic push_item(input logic func, input pix_t p);
		px_item_t it;
		it.func  = func;
		it.red   = p[23:16];
		it.green = p[15:8];
		it.blue  = p[7:0];
		pending_items.push_back(it);
		if (func == FUNC_PIXEL)
			pixels_sent++;
		else
			flushes_sent++;
	endtask

	// Block idle: all stimulus taken, nothing owed, pipeline given time to empty
	task automatic wait_quiet();
		do begin
			@(posedge clk);
			#1;
		end while (pending_items.size() != 0 || s_axis_tvalid || expected_pixels.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(input logic idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	function automatic pix_t make_pixel(input int style);
		pix_t        palette[6];
		logic [7:0]  level;
		palette = '{TIE_A, TIE_B, TIE_C, TIE_D, 24'h000000, 24'hFFFFFF};
		level   = $urandom_range(255);
		case (style)
			STYLE_PALETTE: return palette[$urandom_range(5)];
			STYLE_GRAY:    return {level, level, level};
			default:       return pix_t'($urandom);
		endcase
	endfunction

	// Drain the frame. With mixed set, drain steps may be pixels, which count as flushes;
	// the last step is always a flush so nothing spills into the next frame.
	task automatic close_frame(input bit mixed);
		int unsigned steps;
		wait_quiet();
		while (col_ct != 0 || row_ct != 0) begin
			steps = eff_width() + 1;
			mixed = mixed && row_ct == eff_height() && col_ct == 0;
			for (int unsigned k = 0; k < steps; k++)
				if (mixed && k + 1 < steps && $urandom_range(1) == 1)
					push_item(FUNC_PIXEL, pix_t'($urandom));
				else
					push_item(FUNC_FLUSH, pix_t'($urandom));
			wait_quiet();
			mixed = 1'b0;
		end
	endtask

	initial begin
		int unsigned wv, hv, ew, eh, style, random_pixels;
		for (int i = 0; i < MAX_WIDTH; i++) begin
			upper_row[i]  = '0;
			middle_row[i] = '0;
		end
		for (int i = 0; i < WIN_N; i++)
			window[i] = '0;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// 3x3 frame: one interior pixel; black, white, primaries and two equal-luma
		// colors so the tie rule decides. A flush mid-frame must be ignored, and a
		// pixel among the drain steps acts as a flush.
		write_cfg(REG_IMAGE_WIDTH, 16'd3);
		write_cfg(REG_IMAGE_HEIGHT, 16'd3);
		push_item(FUNC_PIXEL, 24'h000000);
		push_item(FUNC_PIXEL, 24'hFFFFFF);
		push_item(FUNC_PIXEL, TIE_A);
		push_item(FUNC_FLUSH, 24'hFFFFFF);
		push_item(FUNC_PIXEL, TIE_B);
		push_item(FUNC_PIXEL, TIE_A);
		push_item(FUNC_PIXEL, 24'hFF0000);
		push_item(FUNC_PIXEL, 24'h00FF00);
		push_item(FUNC_PIXEL, 24'h0000FF);
		push_item(FUNC_PIXEL, TIE_B);
		push_item(FUNC_FLUSH, 24'h000000);
		push_item(FUNC_PIXEL, 24'h123456);
		push_item(FUNC_FLUSH, 24'h000000);
		push_item(FUNC_FLUSH, 24'h000000);
		push_item(FUNC_FLUSH, 24'h000000);   // already at the next frame: ignored
		close_frame(1'b0);

		// zero width and height behave as 1x1; drain has an empty step
		write_cfg(REG_IMAGE_WIDTH, 16'd0);
		write_cfg(REG_IMAGE_HEIGHT, 16'd0);
		push_item(FUNC_PIXEL, 24'h5AA55A);
		close_frame(1'b0);

		write_cfg(REG_IMAGE_WIDTH, 16'd2);
		write_cfg(REG_IMAGE_HEIGHT, 16'd2);
		push_item(FUNC_PIXEL, 24'h807F01);
		push_item(FUNC_PIXEL, 24'h01FE80);
		push_item(FUNC_PIXEL, 24'hAA5500);
		push_item(FUNC_PIXEL, 24'h0055AA);
		close_frame(1'b1);

		// Geometry changed inside a frame: width lowered below the current column,
		// raised again, then height cut below the current row so the frame ends early.
		write_cfg(REG_IMAGE_WIDTH, 16'd6);
		write_cfg(REG_IMAGE_HEIGHT, 16'hFFFF);
		repeat (20) push_item(FUNC_PIXEL, make_pixel(STYLE_NOISE));
		wait_quiet();
		write_cfg(REG_IMAGE_WIDTH, 16'd2);
		repeat (7) push_item(FUNC_PIXEL, make_pixel(STYLE_PALETTE));
		wait_quiet();
		write_cfg(REG_IMAGE_WIDTH, 16'd5);
		repeat (8) push_item(FUNC_PIXEL, make_pixel(STYLE_NOISE));
		wait_quiet();
		write_cfg(REG_IMAGE_HEIGHT, 16'd2);
		repeat (2) push_item(FUNC_PIXEL, make_pixel(STYLE_NOISE));
		close_frame(1'b0);

		// Wider frame: a stretch with no idling on either side, then the receiver holds
		// off once outputs flow while the sender keeps offering.
		write_cfg(REG_IMAGE_WIDTH, 16'(PRESS_W));
		write_cfg(REG_IMAGE_HEIGHT, 16'(PRESS_H));
		gap_from = in_taken + 5;
		gap_to   = in_taken + 75;
		hold_at  = in_taken + 80;
		for (int k = 0; k < PRESS_W * PRESS_H; k++)
			push_item(FUNC_PIXEL, make_pixel(k < PRESS_W ? STYLE_NOISE : $urandom_range(2)));
		close_frame(1'b1);

		// Random small frames, ignored flushes sprinkled in as noise
		random_pixels = 0;
		while (random_pixels < RANDOM_PIXELS) begin
			wv = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 8);
			hv = ($urandom_range(9) == 0) ? $urandom_range(7, 12) : $urandom_range(0, 6);
			write_cfg(REG_IMAGE_WIDTH, {4'($urandom), 12'(wv)});
			write_cfg(REG_IMAGE_HEIGHT, 16'(hv));
			ew    = eff_width();
			eh    = eff_height();
			style = $urandom_range(2);
			for (int unsigned k = 0; k < ew * eh; k++) begin
				if ($urandom_range(11) == 0)
					push_item(FUNC_FLUSH, pix_t'($urandom));
				push_item(FUNC_PIXEL, make_pixel(style));
			end
			random_pixels += ew * eh;
			close_frame($urandom_range(1));
		end

		wait_quiet();
		$display("%0d frames, %0d pixels and %0d flushes (%0d ignored) sent",
			frames_closed, pixels_sent, flushes_sent, flushes_ignored);
		$display("%0d results checked, %0d of them median-filtered, %0d mismatches",
			results_checked, filtered_seen, mismatch_ct);
		if (mismatch_ct == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
